### rtl/well_pkg.sv
// ============================================================================
// well_pkg
// Request codes, tap offsets and mixing constants of the WELL19937a generator.
// ============================================================================
package well_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [31:0] word_t;
    typedef logic [63:0] dword_t;

    localparam mode_t MODE_GENERATE = 2'd0;
    localparam mode_t MODE_LOAD     = 2'd1;
    localparam mode_t MODE_RESEED   = 2'd2;

    localparam int unsigned TAP_A = 70;
    localparam int unsigned TAP_B = 179;
    localparam int unsigned TAP_C = 449;

    localparam word_t UPPER_MASK = 32'h8000_0000;
    localparam word_t LOWER_MASK = 32'h7fff_ffff;

    localparam dword_t MIX_GOLDEN  = 64'h9e37_79b9_7f4a_7c15;
    localparam dword_t MIX_MULT_1  = 64'hbf58_476d_1ce4_e5b9;
    localparam dword_t MIX_MULT_2  = 64'h94d0_49bb_1331_11eb;
    localparam dword_t MIX_DEFAULT = 64'h853c_49e6_748f_ea9b;

endpackage

### rtl/well19937a_generator.sv
// ============================================================================
// well19937a_generator
// WELL19937a word generator over a ring held in a dual-read memory.
// ============================================================================
// Requests enter on s_valid/s_ready and carry s_mode with its seed fields.
// A generate request yields one m_random_word on m_valid/m_ready; load and
// reseed requests yield nothing.
// Generate: a seeded request passes GEN_RD1, GEN_RD2, GEN_CALC and GEN_WR,
// where the result is registered; a new request is taken only once the block
// is back in IDLE. The cost is six ring reads on the two read ports plus two
// writes on the single write port. Before any seeding a generate returns 0.
// Load: one raw word per cycle; after the word that completes the ring the
// block passes FIX_WORD, forcing word 0, when the ring came out all zero.
// Reseed: each splitmix64 value passes MIX_ADD, MIX_MUL, MIX_MID, MIX_MUL,
// MIX_WR_LO and MIX_WR_HI (one 32x32 multiplier shared over two 64-bit
// products), two ring words per value, plus FIX_WORD for an all-zero ring.
// Reset clears the index, load count, seeded flag and output slot; the ring
// holds no defined value until seeded. A stalled receiver holds the result in
// the output register while the next request is still taken; a generate that
// finishes against a full output register waits for it to drain.
// ============================================================================
module well19937a_generator #(
    parameter int unsigned RING_DEPTH = 624
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_seed_word,
    input  logic [63:0] s_seed_value,
    input  logic        s_seed_given,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word
);

    localparam int unsigned IDX_W = $clog2(RING_DEPTH);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN_RD1,
        ST_GEN_RD2,
        ST_GEN_CALC,
        ST_GEN_WR,
        ST_GEN_ZERO,
        ST_FIX_WORD,
        ST_MIX_ADD,
        ST_MIX_MUL,
        ST_MIX_MID,
        ST_MIX_WR_LO,
        ST_MIX_WR_HI
    } state_t;

    function automatic idx_t wrap_add(input idx_t base, input logic [IDX_W:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= (IDX_W + 1)'(RING_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(RING_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    well_pkg::word_t ring_mem [RING_DEPTH];

    state_t           state_reg;
    idx_t             ring_index_reg;
    idx_t             load_count_reg;
    logic             nonzero_seen_reg;
    logic             seeded_reg;
    well_pkg::dword_t mixer_value_reg;
    idx_t             fill_idx_reg;
    well_pkg::dword_t z_reg;
    well_pkg::dword_t acc_reg;
    well_pkg::dword_t prod_reg;
    logic [1:0]       mul_step_reg;
    logic             mul_sel_reg;
    well_pkg::word_t  mix_hi_reg;
    well_pkg::word_t  v0_reg;
    well_pkg::word_t  va_reg;
    well_pkg::word_t  vb_reg;
    well_pkg::word_t  vc_reg;
    well_pkg::word_t  nb_reg;
    well_pkg::word_t  rd_a_reg;
    well_pkg::word_t  rd_b_reg;
    logic             out_valid_reg;
    well_pkg::word_t  out_word_reg;

    logic             accept;
    logic             slot_free;
    logic             out_load;
    idx_t             cur_addr;
    idx_t             back1_addr;
    idx_t             back2_addr;
    idx_t             pa_addr;
    idx_t             pb_addr;
    idx_t             pc_addr;
    idx_t             rd_addr_a;
    idx_t             rd_addr_b;
    logic             wr_en;
    idx_t             wr_addr;
    well_pkg::word_t  wr_data;
    well_pkg::word_t  t0;
    well_pkg::word_t  t1;
    well_pkg::word_t  t2;
    well_pkg::word_t  n1;
    well_pkg::word_t  nb;
    well_pkg::dword_t ctr_next;
    well_pkg::dword_t mix_out;
    well_pkg::dword_t mul_const;
    well_pkg::word_t  mul_a;
    well_pkg::word_t  mul_b;
    well_pkg::dword_t prod_next;
    logic             mix_done;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign slot_free     = !out_valid_reg || m_ready;
    assign out_load      = slot_free
                           && ((state_reg == ST_GEN_WR) || (state_reg == ST_GEN_ZERO));
    assign m_valid       = out_valid_reg;
    assign m_random_word = out_word_reg;

    assign cur_addr   = ring_index_reg;
    assign back1_addr = wrap_add(ring_index_reg, (IDX_W + 1)'(RING_DEPTH - 1));
    assign back2_addr = wrap_add(ring_index_reg, (IDX_W + 1)'(RING_DEPTH - 2));
    assign pa_addr    = wrap_add(ring_index_reg, (IDX_W + 1)'(well_pkg::TAP_A));
    assign pb_addr    = wrap_add(ring_index_reg, (IDX_W + 1)'(well_pkg::TAP_B));
    assign pc_addr    = wrap_add(ring_index_reg, (IDX_W + 1)'(well_pkg::TAP_C));

    // recurrence, with back1 and back2 arriving on the read ports
    assign t0 = (rd_a_reg & well_pkg::UPPER_MASK) | (rd_b_reg & well_pkg::LOWER_MASK);
    assign t1 = (v0_reg ^ (v0_reg << 25)) ^ (va_reg ^ (va_reg >> 27));
    assign t2 = (vb_reg >> 9) ^ (vc_reg ^ (vc_reg >> 1));
    assign n1 = t1 ^ t2;
    assign nb = t0 ^ (t1 ^ (t1 << 9)) ^ (t2 ^ (t2 << 21)) ^ (n1 ^ (n1 >> 21));

    assign ctr_next  = mixer_value_reg + well_pkg::MIX_GOLDEN;
    assign mix_out   = acc_reg ^ (acc_reg >> 31);
    assign mul_const = mul_sel_reg ? well_pkg::MIX_MULT_2 : well_pkg::MIX_MULT_1;
    assign mul_a     = (mul_step_reg == 2'd1) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (mul_step_reg == 2'd2) ? mul_const[63:32] : mul_const[31:0];
    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    assign mix_done  = (fill_idx_reg == IDX_W'(RING_DEPTH - 2));

    always_comb begin
        rd_addr_a = cur_addr;
        rd_addr_b = pa_addr;
        unique case (state_reg)
            ST_GEN_RD1: begin
                rd_addr_a = pc_addr;
                rd_addr_b = pb_addr;
            end
            ST_GEN_RD2: begin
                rd_addr_a = back1_addr;
                rd_addr_b = back2_addr;
            end
            default: begin
                rd_addr_a = cur_addr;
                rd_addr_b = pa_addr;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = n1;
        unique case (state_reg)
            ST_IDLE: begin
                wr_en   = accept && (s_mode == well_pkg::MODE_LOAD);
                wr_addr = load_count_reg;
                wr_data = s_seed_word;
            end
            ST_GEN_CALC: begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = n1;
            end
            ST_GEN_WR: begin
                wr_en   = slot_free;
                wr_addr = back1_addr;
                wr_data = nb_reg;
            end
            ST_FIX_WORD: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = well_pkg::UPPER_MASK;
            end
            ST_MIX_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = fill_idx_reg;
                wr_data = mix_out[31:0];
            end
            ST_MIX_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = fill_idx_reg + IDX_W'(1);
                wr_data = mix_hi_reg;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = cur_addr;
                wr_data = n1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= ring_mem[rd_addr_a];
        rd_b_reg <= ring_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ring_index_reg   <= '0;
            load_count_reg   <= '0;
            nonzero_seen_reg <= 1'b0;
            seeded_reg       <= 1'b0;
            mixer_value_reg  <= '0;
            out_valid_reg    <= 1'b0;
            fill_idx_reg     <= '0;
            mul_step_reg     <= '0;
            mul_sel_reg      <= 1'b0;
        end else begin
            prod_reg <= prod_next;
            if (out_valid_reg && m_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_mode)
                            well_pkg::MODE_GENERATE: begin
                                state_reg <= seeded_reg ? ST_GEN_RD1 : ST_GEN_ZERO;
                            end
                            well_pkg::MODE_LOAD: begin
                                if (load_count_reg == IDX_W'(RING_DEPTH - 1)) begin
                                    ring_index_reg   <= '0;
                                    seeded_reg       <= 1'b1;
                                    load_count_reg   <= '0;
                                    nonzero_seen_reg <= 1'b0;
                                    if (!nonzero_seen_reg && (s_seed_word == '0)) begin
                                        state_reg <= ST_FIX_WORD;
                                    end
                                end else begin
                                    load_count_reg   <= load_count_reg + IDX_W'(1);
                                    nonzero_seen_reg <= nonzero_seen_reg
                                                        || (s_seed_word != '0);
                                end
                            end
                            well_pkg::MODE_RESEED: begin
                                mixer_value_reg  <= s_seed_given ? s_seed_value
                                                                 : well_pkg::MIX_DEFAULT;
                                fill_idx_reg     <= '0;
                                load_count_reg   <= '0;
                                nonzero_seen_reg <= 1'b0;
                                state_reg        <= ST_MIX_ADD;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_GEN_RD1: begin
                    v0_reg    <= rd_a_reg;
                    va_reg    <= rd_b_reg;
                    state_reg <= ST_GEN_RD2;
                end
                ST_GEN_RD2: begin
                    vc_reg    <= rd_a_reg;
                    vb_reg    <= rd_b_reg;
                    state_reg <= ST_GEN_CALC;
                end
                ST_GEN_CALC: begin
                    nb_reg    <= nb;
                    state_reg <= ST_GEN_WR;
                end
                ST_GEN_WR: begin
                    if (slot_free) begin
                        out_valid_reg  <= 1'b1;
                        out_word_reg   <= nb_reg;
                        ring_index_reg <= back1_addr;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_GEN_ZERO: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_FIX_WORD: begin
                    state_reg <= ST_IDLE;
                end
                ST_MIX_ADD: begin
                    mixer_value_reg <= ctr_next;
                    z_reg           <= ctr_next ^ (ctr_next >> 30);
                    mul_step_reg    <= '0;
                    mul_sel_reg     <= 1'b0;
                    state_reg       <= ST_MIX_MUL;
                end
                ST_MIX_MUL: begin
                    mul_step_reg <= mul_step_reg + 2'd1;
                    case (mul_step_reg)
                        2'd0: begin
                            acc_reg <= acc_reg;
                        end
                        2'd1: begin
                            acc_reg <= prod_reg;
                        end
                        default: begin
                            acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                        end
                    endcase
                    if (mul_step_reg == 2'd3) begin
                        state_reg <= mul_sel_reg ? ST_MIX_WR_LO : ST_MIX_MID;
                    end
                end
                ST_MIX_MID: begin
                    z_reg        <= acc_reg ^ (acc_reg >> 27);
                    mul_step_reg <= '0;
                    mul_sel_reg  <= 1'b1;
                    state_reg    <= ST_MIX_MUL;
                end
                ST_MIX_WR_LO: begin
                    mix_hi_reg       <= mix_out[63:32];
                    nonzero_seen_reg <= nonzero_seen_reg || (mix_out[31:0] != '0);
                    state_reg        <= ST_MIX_WR_HI;
                end
                ST_MIX_WR_HI: begin
                    if (mix_done) begin
                        ring_index_reg   <= '0;
                        seeded_reg       <= 1'b1;
                        nonzero_seen_reg <= 1'b0;
                        if (!nonzero_seen_reg && (mix_hi_reg == '0)) begin
                            state_reg <= ST_FIX_WORD;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        nonzero_seen_reg <= nonzero_seen_reg || (mix_hi_reg != '0);
                        fill_idx_reg     <= fill_idx_reg + IDX_W'(2);
                        state_reg        <= ST_MIX_ADD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_index_steps_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GEN_WR && slot_free) |=> ring_index_reg == $past(back1_addr))
        else $error("ring index did not step back after a generated word");

    a_load_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_count_reg < IDX_W'(RING_DEPTH))
        else $error("load count beyond ring depth");

    a_gen_needs_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GEN_RD1) |-> seeded_reg)
        else $error("ring read for generation before seeding");

    a_fill_even: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX_WR_HI) |-> !fill_idx_reg[0])
        else $error("splitmix fill index is odd");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking testbench of the WELL19937a word generator.
// ============================================================================
// A queue of requests is filled up front. It holds a short directed part,
// then random segments: generate bursts, splitmix reseeds, raw loads
// abandoned by a reseed, one complete raw load (all zero or with mixed
// words, picked at random) with generates in the middle, and unused-mode
// noise. A driver presents the requests in bursts with random gaps. The
// receiver stalls in styles picked anew when the stall phase runs out. Each
// accepted request updates a local model of the ring, which predicts the
// generated words; each accepted word is checked in order against them.
// ============================================================================
module tb;

    localparam int unsigned     RING_DEPTH     = 624;
    localparam well_pkg::mode_t MODE_UNUSED    = 2'd3;
    localparam well_pkg::word_t ZERO_RING_FILL = 32'h8000_0000;
    localparam int unsigned     ITEM_TARGET    = 750;
    localparam int unsigned     LOAD_POINT     = (ITEM_TARGET - RING_DEPTH) / 2;
    localparam int unsigned     IDLE_LIMIT     = 20000;
    localparam int unsigned     DRAIN_CYCLES   = 50;
    localparam int unsigned     RESET_CYCLES   = 7;
    localparam int unsigned     REPORT_LINES   = 100;

    localparam int unsigned READY_ALWAYS   = 0;
    localparam int unsigned READY_RANDOM   = 1;
    localparam int unsigned READY_PERIODIC = 2;

    typedef struct {
        well_pkg::mode_t  mode;
        well_pkg::word_t  word;
        well_pkg::dword_t value;
        logic             given;
    } well_request_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    well_pkg::mode_t  s_mode       = well_pkg::MODE_GENERATE;
    well_pkg::word_t  s_seed_word  = '0;
    well_pkg::dword_t s_seed_value = '0;
    logic             s_seed_given = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    well_pkg::word_t  m_random_word;

    well_request_t    pending_requests[$];
    well_pkg::word_t  expected_words[$];
    int unsigned      request_total  = 0;
    int unsigned      request_count  = 0;
    int unsigned      accepted_count = 0;
    int unsigned      idle_cycles    = 0;
    int unsigned      error_count    = 0;
    logic             req_taken      = 1'b0;

    int unsigned      burst_left   = 0;
    int unsigned      gap_left     = 0;
    int unsigned      stall_phase  = 0;
    int unsigned      stall_style  = READY_ALWAYS;
    int unsigned      stall_period = 2;

    well_pkg::word_t  ring_model [RING_DEPTH];
    int unsigned      index_model   = 0;
    int unsigned      loaded_model  = 0;
    bit               nonzero_model = 1'b0;
    bit               seeded_model  = 1'b0;
    well_pkg::dword_t mixer_model   = '0;

    well19937a_generator #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_seed_word  (s_seed_word),
        .s_seed_value (s_seed_value),
        .s_seed_given (s_seed_given),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_random_word(m_random_word)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LINES) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    function automatic well_pkg::word_t advance_well();
        int unsigned     cur, back1, back2, pa, pb, pc;
        well_pkg::word_t v0, va, vc, t0, t1, t2, n1;
        cur   = index_model;
        back1 = (cur + RING_DEPTH - 1) % RING_DEPTH;
        back2 = (cur + RING_DEPTH - 2) % RING_DEPTH;
        pa    = (cur + well_pkg::TAP_A) % RING_DEPTH;
        pb    = (cur + well_pkg::TAP_B) % RING_DEPTH;
        pc    = (cur + well_pkg::TAP_C) % RING_DEPTH;
        v0    = ring_model[cur];
        va    = ring_model[pa];
        vc    = ring_model[pc];
        t0    = (ring_model[back1] & well_pkg::UPPER_MASK)
                | (ring_model[back2] & well_pkg::LOWER_MASK);
        t1    = (v0 ^ (v0 << 25)) ^ (va ^ (va >> 27));
        t2    = (ring_model[pb] >> 9) ^ (vc ^ (vc >> 1));
        n1    = t1 ^ t2;
        ring_model[cur]   = n1;
        ring_model[back1] = t0 ^ (t1 ^ (t1 << 9)) ^ (t2 ^ (t2 << 21)) ^ (n1 ^ (n1 >> 21));
        index_model       = back1;
        return ring_model[back1];
    endfunction

    function automatic void close_seed(input bit any_nonzero);
        index_model = 0;
        if (!any_nonzero) begin
            ring_model[0] = ZERO_RING_FILL;
        end
        seeded_model  = 1'b1;
        loaded_model  = 0;
        nonzero_model = 1'b0;
    endfunction

    function automatic well_pkg::dword_t splitmix_scramble(input well_pkg::dword_t z);
        z = (z ^ (z >> 30)) * well_pkg::MIX_MULT_1;
        z = (z ^ (z >> 27)) * well_pkg::MIX_MULT_2;
        return z ^ (z >> 31);
    endfunction

    function automatic void reseed_ring(input well_pkg::dword_t start);
        well_pkg::dword_t ctr, mixed;
        bit               any_nonzero;
        int unsigned      i;
        ctr         = start;
        any_nonzero = 1'b0;
        for (i = 0; i < RING_DEPTH; i += 2) begin
            ctr               += well_pkg::MIX_GOLDEN;
            mixed              = splitmix_scramble(ctr);
            ring_model[i]      = mixed[31:0];
            ring_model[i + 1]  = mixed[63:32];
            any_nonzero       |= (mixed != '0);
        end
        mixer_model = ctr;
        close_seed(any_nonzero);
    endfunction

    function automatic void model_request(input well_pkg::mode_t mode,
                                          input well_pkg::word_t word,
                                          input well_pkg::dword_t value, input logic given);
        case (mode)
            well_pkg::MODE_GENERATE: begin
                if (seeded_model) begin
                    expected_words.push_back(advance_well());
                end else begin
                    expected_words.push_back('0);
                end
            end
            well_pkg::MODE_LOAD: begin
                ring_model[loaded_model] = word;
                if (word != '0) begin
                    nonzero_model = 1'b1;
                end
                loaded_model++;
                if (loaded_model >= RING_DEPTH) begin
                    close_seed(nonzero_model);
                end
            end
            well_pkg::MODE_RESEED: begin
                reseed_ring(given ? value : well_pkg::MIX_DEFAULT);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic push_request(input well_pkg::mode_t mode, input well_pkg::word_t word,
                                input well_pkg::dword_t value, input logic given);
        well_request_t req;
        req.mode  = mode;
        req.word  = word;
        req.value = value;
        req.given = given;
        pending_requests.push_back(req);
        if (mode != MODE_UNUSED) begin
            request_count++;
        end
    endtask

    function automatic well_pkg::word_t random_ring_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return well_pkg::word_t'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic well_pkg::dword_t random_seed_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_generates(input int unsigned count);
        repeat (count) begin
            push_request(well_pkg::MODE_GENERATE, $urandom, {$urandom, $urandom},
                         1'($urandom_range(0, 1)));
        end
    endtask

    task automatic push_load(input well_pkg::word_t word);
        push_request(well_pkg::MODE_LOAD, word, {$urandom, $urandom},
                     1'($urandom_range(0, 1)));
    endtask

    task automatic push_reseed(input logic given, input well_pkg::dword_t value);
        push_request(well_pkg::MODE_RESEED, $urandom, value, given);
    endtask

    task automatic push_noise();
        push_request(MODE_UNUSED, $urandom, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_random_reseed();
        push_reseed($urandom_range(0, 3) != 0, random_seed_value());
    endtask

    task automatic push_full_load(input bit all_zero);
        int unsigned mid;
        int unsigned i;
        mid = $urandom_range(1, RING_DEPTH - 2);
        for (i = 0; i < RING_DEPTH; i++) begin
            push_load(all_zero ? well_pkg::word_t'(0) : random_ring_word());
            if (i == mid || $urandom_range(0, 99) == 0) begin
                push_generates($urandom_range(1, 3));
            end
            if ($urandom_range(0, 149) == 0) begin
                push_noise();
            end
        end
    endtask

    task automatic push_abandoned_load();
        repeat ($urandom_range(1, 40)) begin
            push_load(random_ring_word());
            if ($urandom_range(0, 9) == 0) begin
                push_generates(1);
            end
        end
        push_random_reseed();
    endtask

    task automatic push_random_segment();
        case ($urandom_range(0, 19))
            1, 2:    push_random_reseed();
            3:       push_abandoned_load();
            4:       push_noise();
            default: push_generates($urandom_range(1, 24));
        endcase
    endtask

    always @(negedge aclk) begin : drive_requests
        well_request_t req;
        if (aresetn && !(s_valid && !req_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                req           = pending_requests.pop_front();
                s_valid      <= 1'b1;
                s_mode       <= req.mode;
                s_seed_word  <= req.word;
                s_seed_value <= req.value;
                s_seed_given <= req.given;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_ready
        if (stall_phase == 0) begin
            stall_style  <= $urandom_range(READY_ALWAYS, READY_PERIODIC);
            stall_period <= $urandom_range(2, 9);
            stall_phase  <= 63;
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_style)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default:      m_ready <= (stall_phase % stall_period) != 0;
        endcase
    end

    always @(posedge aclk) begin : watch_channels
        well_pkg::word_t expected_word;
        if (!aresetn) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected random_word %h", m_random_word));
                end else begin
                    expected_word = expected_words.pop_front();
                    if (m_random_word !== expected_word) begin
                        report_mismatch($sformatf("random_word %h, expected %h",
                                                  m_random_word, expected_word));
                    end
                end
            end
            if (s_valid && s_ready) begin
                model_request(s_mode, s_seed_word, s_seed_value, s_seed_given);
                accepted_count <= accepted_count + 1;
            end
            req_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        bit zero_load;
        zero_load = 1'($urandom_range(0, 1));

        // unseeded generates, noise, partial load abandoned by a default reseed
        push_generates(2);
        push_noise();
        push_load('0);
        push_load('1);
        push_load(32'h0000_0001);
        push_load(32'h8000_0000);
        push_generates(1);
        push_reseed(1'b0, '1);
        push_generates(3);
        push_noise();
        push_reseed(1'b1, '0);
        push_generates(2);
        push_reseed(1'b1, '1);
        push_generates(2);
        push_load($urandom);
        push_load($urandom);
        push_generates(1);
        push_load($urandom);
        push_reseed(1'b1, {32'h0, $urandom});
        push_generates(2);

        while (request_count < LOAD_POINT) begin
            push_random_segment();
        end
        push_full_load(zero_load);
        push_generates($urandom_range(1, 24));
        while (request_count < ITEM_TARGET) begin
            push_random_segment();
        end
        push_generates(8);
        request_total = pending_requests.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while ((accepted_count != request_total || expected_words.size() != 0)
               && idle_cycles < IDLE_LIMIT) begin
            @(negedge aclk);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            report_mismatch($sformatf("watchdog: nothing accepted for %0d cycles",
                                      idle_cycles));
        end else begin
            repeat (DRAIN_CYCLES) @(negedge aclk);
            if (expected_words.size() != 0) begin
                report_mismatch($sformatf("%0d expected words never arrived",
                                          expected_words.size()));
            end
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/well_pkg.sv
rtl/well19937a_generator.sv
test/tb.sv
